/* hw/rtl/mpfm_pkg.sv */
// Shared types, constants and register indexes for the masked pattern search.
package mpfm_pkg;

  // window depth and width of the byte counter
  localparam int MAX_PATTERN = 32;
  localparam int OFFSET_BITS = 32;

  // pattern slots in the configuration registers
  localparam int CFG_SLOTS = 32;
  localparam int SLOT_BITS = $clog2(CFG_SLOTS);
  localparam int LEN_BITS  = 6;
  localparam int LEN_CAP   = (MAX_PATTERN < CFG_SLOTS) ? MAX_PATTERN : CFG_SLOTS;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;
  localparam int RESULT_BITS   = 32;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_0_7   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_8_15  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_16_23 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAT_24_31 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WILDCARD  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH    = 3'd5;

  typedef logic [7:0]               byte_t;
  typedef logic [OFFSET_BITS-1:0]   count_t;
  typedef logic [LEN_BITS-1:0]      len_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // pattern as seen from the window: entry k lines up with the byte k beats old
  typedef struct packed {
    logic  [MAX_PATTERN-1:0] active;
    byte_t [MAX_PATTERN-1:0] abyte;
    len_t                    len;
  } pattern_view_t;

  typedef struct packed {
    logic                   found;
    logic [RESULT_BITS-1:0] match_offset;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } result_push_t;

endpackage

/* hw/rtl/mpfm_if.sv */
// Stream interfaces: image bytes in, search results out.
interface mpfm_byte_if;
  logic               valid;
  logic               ready;
  mpfm_pkg::byte_t    data_byte;
  logic               last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mpfm_result_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   found;
  logic [mpfm_pkg::RESULT_BITS-1:0]       match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* hw/rtl/masked_pattern_first_match.sv */
// Top level of the masked byte pattern search.
//
// Image bytes arrive on the bytes channel, one beat per byte, with last_byte
// set on the final byte of each image. Each image gives exactly one beat on
// the results channel: found with the start offset of the first match, or
// found low and offset zero when the image ends without a match. A match
// ending on the last byte counts as found.
// The pattern, its wildcard mask and its length are written through the
// cfg_we / cfg_index / cfg_data port; the user must write them only while no
// image is in flight; the block itself does not enforce this. Throughput:
// one byte per cycle while the result queue has a free slot; the window
// compare is a single combinational pass over all 32 window entries.
// The result queue holds two beats; bytes are taken while a slot is free,
// so a stalled receiver holds off the byte stream only once both are full.
// Reset clears the window, the count, the result queue and the registers
// (pattern length reads as one).
module masked_pattern_first_match (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  mpfm_pkg::cfg_idx_t   cfg_index,
  input  mpfm_pkg::cfg_data_t  cfg_data,
  mpfm_byte_if.sink            bytes,
  mpfm_result_if.source        results
);

  mpfm_pkg::pattern_view_t view;
  mpfm_pkg::result_push_t  push;
  logic                    space;
  logic                    accept;

  assign bytes.ready = space;
  assign accept      = bytes.valid && space;

  mpfm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  mpfm_match u_match (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (bytes.data_byte),
    .last_byte (bytes.last_byte),
    .view      (view),
    .push      (push)
  );

  mpfm_out u_out (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .space   (space),
    .results (results)
  );

endmodule

/* hw/rtl/mpfm_cfg.sv */
// Configuration registers and the window-aligned view of the pattern.
module mpfm_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  mpfm_pkg::cfg_idx_t        cfg_index,
  input  mpfm_pkg::cfg_data_t       cfg_data,
  output mpfm_pkg::pattern_view_t   view
);

  logic [3:0][63:0]                           pat;
  logic [mpfm_pkg::CFG_SLOTS-1:0]             wild;
  mpfm_pkg::len_t                             plen;
  mpfm_pkg::byte_t [mpfm_pkg::CFG_SLOTS-1:0]  pbytes;
  mpfm_pkg::len_t                             len;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pat  <= '0;
      wild <= '0;
      plen <= mpfm_pkg::LEN_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mpfm_pkg::CFG_PAT_0_7:   pat[0] <= cfg_data;
        mpfm_pkg::CFG_PAT_8_15:  pat[1] <= cfg_data;
        mpfm_pkg::CFG_PAT_16_23: pat[2] <= cfg_data;
        mpfm_pkg::CFG_PAT_24_31: pat[3] <= cfg_data;
        mpfm_pkg::CFG_WILDCARD:  wild   <= cfg_data[mpfm_pkg::CFG_SLOTS-1:0];
        mpfm_pkg::CFG_LENGTH:    plen   <= cfg_data[mpfm_pkg::LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign pbytes = pat;

  // zero length reads as one, long lengths clamp
  always_comb begin
    if (plen == '0)
      len = mpfm_pkg::LEN_BITS'(1);
    else if (plen > mpfm_pkg::LEN_BITS'(mpfm_pkg::LEN_CAP))
      len = mpfm_pkg::LEN_BITS'(mpfm_pkg::LEN_CAP);
    else
      len = plen;
  end

  // window entry k holds pattern byte len-1-k
  always_comb begin
    logic [mpfm_pkg::LEN_BITS-1:0] idx;
    view.len = len;
    for (int k = 0; k < mpfm_pkg::MAX_PATTERN; k++) begin
      idx = len - mpfm_pkg::LEN_BITS'(k) - mpfm_pkg::LEN_BITS'(1);
      view.abyte[k]  = pbytes[idx[mpfm_pkg::SLOT_BITS-1:0]];
      view.active[k] = (k < int'(len)) && !wild[idx[mpfm_pkg::SLOT_BITS-1:0]];
    end
  end

endmodule

/* hw/rtl/mpfm_match.sv */
// Byte window, byte counter and the parallel masked compare.
module mpfm_match (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  mpfm_pkg::byte_t          data_byte,
  input  logic                     last_byte,
  input  mpfm_pkg::pattern_view_t  view,
  output mpfm_pkg::result_push_t   push
);

  mpfm_pkg::byte_t [mpfm_pkg::MAX_PATTERN-1:0] window;
  mpfm_pkg::byte_t [mpfm_pkg::MAX_PATTERN-1:0] window_next;
  mpfm_pkg::count_t                            bytes_seen;
  mpfm_pkg::count_t                            bytes_seen_next;
  logic                                        reported;
  logic                                        hit;
  logic                                        long_enough;

  // shift in the new beat, newest at entry 0
  always_comb begin
    window_next[0] = data_byte;
    for (int k = 1; k < mpfm_pkg::MAX_PATTERN; k++)
      window_next[k] = window[k-1];
  end

  // saturating count
  assign bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 1'b1;
  assign long_enough =
    bytes_seen_next >= mpfm_pkg::count_t'(view.len);

  // masked compare over the whole window
  always_comb begin
    hit = long_enough;
    for (int k = 0; k < mpfm_pkg::MAX_PATTERN; k++)
      if (view.active[k] && window_next[k] != view.abyte[k])
        hit = 1'b0;
  end

  // one result per image: first match, or not found on the last beat
  always_comb begin
    push.valid            = accept && !reported && (hit || last_byte);
    push.res.found        = hit;
    push.res.match_offset = hit ?
      mpfm_pkg::RESULT_BITS'(bytes_seen_next - mpfm_pkg::count_t'(view.len)) : '0;
  end

  // window and counter; the last beat rearms
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      bytes_seen <= '0;
      reported   <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        window     <= '0;
        bytes_seen <= '0;
        reported   <= 1'b0;
      end else begin
        window     <= window_next;
        bytes_seen <= bytes_seen_next;
        if (push.valid)
          reported <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/mpfm_out.sv */
// Two-entry result queue: output register plus skid slot.
module mpfm_out (
  input  logic                    clk,
  input  logic                    rst,
  input  mpfm_pkg::result_push_t  push,
  output logic                    space,
  mpfm_result_if.source           results
);

  mpfm_pkg::result_t [1:0] q;
  logic [1:0]              cnt;
  logic                    pop;

  assign pop           = results.valid && results.ready;
  assign space         = (cnt != 2'd2);
  assign results.valid = (cnt != 2'd0);
  assign results.found        = q[0].found;
  assign results.match_offset = q[0].match_offset;

  // payload slots
  always_ff @(posedge clk) begin
    case ({push.valid, pop})
      2'b10: q[cnt[0]] <= push.res;
      2'b01: q[0] <= q[1];
      2'b11: begin
        if (cnt == 2'd1) begin
          q[0] <= push.res;
        end else begin
          q[0] <= q[1];
          q[1] <= push.res;
        end
      end
      default: ;
    endcase
  end

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push.valid, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* tb/testbench.sv */
// Testbench for the masked byte pattern search: directed cases, then random images.
`timescale 1ns / 1ps

module testbench;
  import mpfm_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_BYTES = 950;
  localparam int IDLE_PCT     = 38;
  localparam int SETTLE       = 4;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  mpfm_byte_if   byte_ch ();
  mpfm_result_if res_ch ();

  masked_pattern_first_match dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bytes     (byte_ch),
    .results   (res_ch)
  );

  // search model state: configuration, window (entry 0 newest), count, report flag
  logic [63:0] pat_word [4] = '{default: '0};
  logic [31:0] wild_mask = '0;
  logic [5:0]  pat_len = 6'd1;
  byte_t       window [MAX_PATTERN] = '{default: '0};
  count_t      seen = '0;
  bit          reported = 1'b0;
  result_t     expected_q [$];

  // run bookkeeping
  bit steady = 1'b0;
  int faults = 0;
  int cycles = 0;
  int hits = 0;
  int misses = 0;
  int images_sent = 0;
  int bytes_sent = 0;
  int settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pattern length as the block uses it: zero reads as one, large values clamp
  function automatic int active_len();
    int n = pat_len;
    if (n == 0) n = 1;
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  function automatic byte_t pat_byte(int j);
    return pat_word[j / 8][(j % 8) * 8 +: 8];
  endfunction

  // add one result to the tail of the expectation queue
  function automatic void expect_result(result_t r);
    expected_q = {expected_q, r};
  endfunction

  // add one byte to the tail of an image
  function automatic void append_byte(ref byte_t img [$], input byte_t b);
    img = {img, b};
  endfunction

  // advance the search model by one accepted byte and queue any result it gives
  task automatic predict_byte(byte_t b, bit last);
    int      n;
    bit      hit;
    result_t r;
    n = active_len();
    for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k - 1];
    window[0] = b;
    if (seen != '1) seen++;
    if (!reported) begin
      hit = (seen >= n);
      for (int j = 0; j < n; j++)
        if (!wild_mask[j] && window[n - 1 - j] != pat_byte(j)) hit = 1'b0;
      if (hit) begin
        r.found        = 1'b1;
        r.match_offset = seen - n;
        reported       = 1'b1;
        expect_result(r);
      end else if (last) begin
        r = '0;
        expect_result(r);
      end
    end
    // end of image rearms the search
    if (last) begin
      foreach (window[k]) window[k] = '0;
      seen     = '0;
      reported = 1'b0;
    end
  endtask

  // one register write, mirrored into the model after the edge
  task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PAT_0_7:   pat_word[0] = value;
      CFG_PAT_8_15:  pat_word[1] = value;
      CFG_PAT_16_23: pat_word[2] = value;
      CFG_PAT_24_31: pat_word[3] = value;
      CFG_WILDCARD:  wild_mask = value[31:0];
      CFG_LENGTH:    pat_len = value[5:0];
      default: ;
    endcase
  endtask

  // writes all six registers; junk puts random data above each narrow register
  task automatic load_pattern(logic [5:0] len_value, logic [63:0] w0, logic [63:0] w1,
                              logic [63:0] w2, logic [63:0] w3, logic [31:0] mask,
                              bit junk);
    logic [57:0] high;
    high = junk ? {26'($urandom), $urandom} : '0;
    write_reg(CFG_PAT_0_7, w0);
    write_reg(CFG_PAT_8_15, w1);
    write_reg(CFG_PAT_16_23, w2);
    write_reg(CFG_PAT_24_31, w3);
    write_reg(CFG_WILDCARD, {high[31:0], mask});
    write_reg(CFG_LENGTH, {high, len_value});
    settings++;
  endtask

  // offer one byte, with random gaps ahead of it outside steady stretches, and wait for its beat
  task automatic send_byte(byte_t b, bit last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk); while (!byte_ch.ready);
    predict_byte(b, last);
    bytes_sent++;
    if (last) images_sent++;
  endtask

  task automatic send_image(byte_t img [$]);
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
  endtask

  // drop valid, wait for every outstanding result, then let the pipeline drain
  task automatic quiesce();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // reset values: one-byte pattern of zero, so a lone zero byte matches at once
  task automatic test_reset_defaults();
    send_image('{8'h00});
    quiesce();
  endtask

  // length zero reads as one; bytes after a report stay silent; a miss reports zero
  task automatic test_short_pattern();
    load_pattern(6'd0, 64'hFF, '0, '0, '0, '0, 1'b0);
    send_image('{8'h00, 8'hFF, 8'h7F});
    send_image('{8'h01, 8'h80});
    quiesce();
  endtask

  // wildcard in the middle, match ends on the last byte
  task automatic test_wildcard_gap();
    load_pattern(6'd3, 64'h30_00_10, '0, '0, '0, 32'h2, 1'b0);
    send_image('{8'h10, 8'hEE, 8'h30});
    quiesce();
  endtask

  // pattern rewritten part way through an image counts from the next byte on
  task automatic test_midimage_rewrite();
    load_pattern(6'd1, 64'hFF, '0, '0, '0, '0, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    quiesce();
    write_reg(CFG_PAT_0_7, 64'h55);
    send_byte(8'h55, 1'b1);
    quiesce();
  endtask

  // oversized length clamps to the full window; only the top byte is fixed
  task automatic test_saturated_length();
    byte_t img [$];
    load_pattern(6'd63, '1, '1, '1, 64'hA5FF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    img = '{8'h00, 8'hFF};
    repeat (29) append_byte(img, byte_t'($urandom));
    append_byte(img, 8'hA5);
    send_image(img);
    quiesce();
  endtask

  // random settings, each followed by a batch of images
  task automatic test_random_images();
    int          start;
    int          sel;
    int          n;
    int          pre;
    logic [5:0]  len_value;
    logic [63:0] w [4];
    logic [31:0] mask;
    byte_t       img [$];
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      steady = (settings % 7 == 3);
      sel = $urandom_range(99);
      if (sel < 8) len_value = 6'd0;
      else if (sel < 16) len_value = 6'($urandom_range(33, 63));
      else if (sel < 28) len_value = 6'($urandom_range(7, 32));
      else len_value = 6'($urandom_range(1, 6));
      foreach (w[i]) w[i] = {$urandom, $urandom};
      sel = $urandom_range(3);
      case (sel)
        0: mask = '0;
        1: mask = '1;
        2: mask = $urandom & $urandom & $urandom;
        default: mask = $urandom;
      endcase
      // extremes of the pattern words
      if (settings % 5 == 0) foreach (w[i]) w[i] = '1;
      if (settings % 5 == 1) foreach (w[i]) w[i] = '0;
      load_pattern(len_value, w[0], w[1], w[2], w[3], mask, $urandom_range(3) == 0);
      n = active_len();
      repeat ($urandom_range(4, 10)) begin
        img.delete();
        sel = $urandom_range(99);
        if (sel < 65) begin
          // planted pattern with random wildcard content, sometimes broken
          pre = ($urandom_range(19) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 10);
          repeat (pre) append_byte(img, byte_t'($urandom));
          for (int j = 0; j < n; j++)
            append_byte(img, wild_mask[j] ? byte_t'($urandom) : pat_byte(j));
          if (sel < 12)
            img[pre + $urandom_range(n - 1)] ^= byte_t'(8'h1 << $urandom_range(7));
          repeat ($urandom_range(0, 8)) append_byte(img, byte_t'($urandom));
        end else begin
          // noise, half of it drawn from the pattern's own bytes
          repeat ($urandom_range(1, 24))
            append_byte(img, $urandom_range(1) ? pat_byte($urandom_range(n - 1))
                                               : byte_t'($urandom));
        end
        send_image(img);
      end
      quiesce();
    end
    steady = 1'b0;
  endtask

  // result receiver: random back-pressure except in steady stretches
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: found=%0b match_offset=%0d",
               res_ch.found, res_ch.match_offset);
        faults++;
      end else begin
        want = expected_q.pop_front();
        if (res_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, res_ch.found);
          faults++;
        end
        if (res_ch.match_offset !== want.match_offset) begin
          $error("match_offset: expected %0d, got %0d",
                 want.match_offset, res_ch.match_offset);
          faults++;
        end
        if (want.found) hits++;
        else misses++;
      end
    end
  end

  // watchdog
  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("masked_pattern_first_match test failed");
    $finish;
  end

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= '0;
    byte_ch.last_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_short_pattern();
    test_wildcard_gap();
    test_midimage_rewrite();
    test_saturated_length();
    test_random_images();

    // drain and let any late beat show up
    quiesce();
    repeat (20) @(posedge clk);
    faults += expected_q.size();

    $display("Scanned %0d images (%0d bytes) under %0d pattern settings.",
             images_sent, bytes_sent, settings);
    $display("Results checked: %0d matches, %0d images without one.", hits, misses);
    if (faults == 0) begin
      $display("masked_pattern_first_match test passed");
    end else begin
      $display("masked_pattern_first_match test failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mpfm_pkg.sv
hw/rtl/mpfm_if.sv
hw/rtl/mpfm_cfg.sv
hw/rtl/mpfm_match.sv
hw/rtl/mpfm_out.sv
hw/rtl/masked_pattern_first_match.sv
tb/testbench.sv
